FILE: rtl/bth_pkg.sv
package bth_pkg;

    // Field widths of the stream payloads
    localparam int REQ_W = 16;
    localparam int REL_W = 14;
    localparam int PAY_W = 14;
    localparam int FB_W  = 15;
    localparam int CFG_W = 15;

    // Heap length after reset, in bytes
    localparam int RESET_BYTES = 16384;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT0,
        ST_INIT1,
        ST_IDLE,
        ST_REL_WR,
        ST_CHK,
        ST_SPLIT,
        ST_MARK,
        ST_W_ISSUE,
        ST_W_DATA,
        ST_W_END,
        ST_FB_RD,
        ST_FB_OUT
    } state_t;

endpackage

FILE: rtl/bth_ram.sv
module bth_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/boundary_tag_heap_allocator.sv
// Channel   Dir  Handshake          Payload
// cfg       in   cfg_we             cfg_wdata = heap_bytes
// s_        in   s_tvalid/s_tready  tdata: request_bytes, release_offset; tuser: kind
// m_        out  m_tvalid/m_tready  tdata: granted, payload_offset, free_bytes
//
// A first-fit walk reads the chunk headers one at a time through the single read port
// of the header RAM, then closes the walk. Reset and every heap_bytes write lay down
// the initial chunk and terminator; s_tready is low meanwhile and during each item.
// A finished result waits in the output register while m_tready is low.
module boundary_tag_heap_allocator #(
    parameter int HEAP_WORDS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_bytes, [29:16] release_offset
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] granted, [14:1] payload_offset, [29:15] free_bytes
);

    localparam int AW    = $clog2(HEAP_WORDS);
    localparam int WC_W  = $clog2(HEAP_WORDS + 1);
    localparam int POS_W = WC_W + 1;
    localparam int HDR_W = $clog2(4 * HEAP_WORDS + 1);
    localparam int CMP_W = (HDR_W + 1 > 18) ? HDR_W + 1 : 18;
    localparam int CW    = (WC_W > 14) ? WC_W : 14;
    localparam int RST_WORDS = (HEAP_WORDS < bth_pkg::RESET_BYTES / 4) ?
                               HEAP_WORDS : bth_pkg::RESET_BYTES / 4;

    bth_pkg::state_t state_reg, state_next;

    logic [WC_W-1:0]  words_reg, words_next;
    logic [POS_W-1:0] free_w_reg, free_w_next;
    logic             free_v_reg, free_v_next;
    logic [CMP_W-1:0] size_reg, size_next;
    logic [HDR_W-1:0] fsize_reg, fsize_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] best_reg, best_next;
    logic [HDR_W-1:0] run_reg, run_next;
    logic [WC_W-1:0]  n_reg, n_next;
    logic [AW-1:0]    rel_w_reg, rel_w_next;
    logic             granted_reg, granted_next;
    logic [bth_pkg::PAY_W-1:0] payload_reg, payload_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg, m_data_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [HDR_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [HDR_W-1:0] ram_rdata;

    logic [bth_pkg::REQ_W-1:0] in_req;
    logic [bth_pkg::REL_W-1:0] in_rel;
    logic                      in_kind;
    logic [CMP_W-1:0]  req_size;
    logic [CW-1:0]     rel_word;
    logic [CW-1:0]     cfg_words_raw;
    logic [WC_W-1:0]   cfg_words;
    logic [WC_W+1:0]   init_hdr;
    logic [HDR_W-1:0]  hdr_sz;
    logic [POS_W-1:0]  step;
    logic [POS_W-1:0]  pos_adv;
    logic [POS_W-1:0]  split_nw;
    logic              fits_split;
    logic [POS_W-1:0]  words_pos;
    logic [bth_pkg::FB_W-1:0] fb_val;

    bth_ram #(
        .WIDTH (HDR_W),
        .DEPTH (HEAP_WORDS)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_req   = s_tdata[15:0];
    assign in_rel   = s_tdata[29:16];
    assign in_kind  = s_tuser[0];
    assign req_size = (CMP_W'(in_req) + CMP_W'(7)) & ~CMP_W'(3);
    assign rel_word = CW'(in_rel >> 2);

    // heap_bytes rounded up to a word and clamped to [2, HEAP_WORDS] words
    assign cfg_words_raw = CW'((16'(cfg_wdata) + 16'd3) >> 2);
    assign cfg_words = (cfg_words_raw < CW'(2)) ? WC_W'(2) :
                       (cfg_words_raw > CW'(HEAP_WORDS)) ? WC_W'(HEAP_WORDS) :
                       WC_W'(cfg_words_raw);

    assign init_hdr   = {words_reg - WC_W'(1), 2'b00};
    assign hdr_sz     = ram_rdata & ~HDR_W'(3);
    assign step       = POS_W'(hdr_sz >> 2);
    assign pos_adv    = pos_reg + step;
    assign split_nw   = free_w_reg + POS_W'(size_reg >> 2);
    assign fits_split = CMP_W'(fsize_reg) >= size_reg + CMP_W'(4);
    assign words_pos  = POS_W'(words_reg);
    assign fb_val     = (free_v_reg && free_w_reg < words_pos) ?
                        bth_pkg::FB_W'(32'(ram_rdata)) : '0;

    assign s_tready = (state_reg == bth_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        words_next   = words_reg;
        free_w_next  = free_w_reg;
        free_v_next  = free_v_reg;
        size_next    = size_reg;
        fsize_next   = fsize_reg;
        p_next       = p_reg;
        pos_next     = pos_reg;
        best_next    = best_reg;
        run_next     = run_reg;
        n_next       = n_reg;
        rel_w_next   = rel_w_reg;
        granted_next = granted_reg;
        payload_next = payload_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        case (state_reg)
            bth_pkg::ST_INIT0: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = HDR_W'(init_hdr);
                state_next = bth_pkg::ST_INIT1;
            end
            bth_pkg::ST_INIT1: begin
                // terminator in the last heap word
                ram_we     = 1'b1;
                ram_waddr  = AW'(words_reg - WC_W'(1));
                ram_wdata  = '0;
                state_next = bth_pkg::ST_IDLE;
            end
            bth_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    granted_next = 1'b0;
                    payload_next = '0;
                    if (in_kind == bth_pkg::KIND_RELEASE) begin
                        if (in_rel >= bth_pkg::REL_W'(4) && rel_word < CW'(words_reg)) begin
                            rel_w_next = AW'(rel_word - CW'(1));
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(rel_word - CW'(1));
                            state_next = bth_pkg::ST_REL_WR;
                        end else begin
                            state_next = bth_pkg::ST_FB_RD;
                        end
                    end else if (in_req == '0) begin
                        state_next = bth_pkg::ST_FB_RD;
                    end else begin
                        size_next = req_size;
                        if (free_v_reg && free_w_reg < words_pos) begin
                            ram_re     = 1'b1;
                            ram_raddr  = free_w_reg[AW-1:0];
                            state_next = bth_pkg::ST_CHK;
                        end else begin
                            pos_next   = '0;
                            best_next  = '0;
                            run_next   = '0;
                            n_next     = '0;
                            state_next = bth_pkg::ST_W_ISSUE;
                        end
                    end
                end
            end
            bth_pkg::ST_REL_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = rel_w_reg;
                ram_wdata  = ram_rdata & ~HDR_W'(1);
                state_next = bth_pkg::ST_FB_RD;
            end
            bth_pkg::ST_CHK: begin
                if (size_reg > CMP_W'(ram_rdata)) begin
                    pos_next   = '0;
                    best_next  = '0;
                    run_next   = '0;
                    n_next     = '0;
                    state_next = bth_pkg::ST_W_ISSUE;
                end else begin
                    fsize_next = ram_rdata;
                    state_next = bth_pkg::ST_SPLIT;
                end
            end
            bth_pkg::ST_SPLIT: begin
                p_next = free_w_reg;
                if (fits_split) begin
                    free_w_next = split_nw;
                    if (split_nw < words_pos) begin
                        ram_we    = 1'b1;
                        ram_waddr = split_nw[AW-1:0];
                        ram_wdata = fsize_reg - HDR_W'(size_reg);
                    end
                end else begin
                    // remainder below a header: hand over the whole chunk
                    free_v_next = 1'b0;
                    size_next   = CMP_W'(fsize_reg);
                end
                state_next = bth_pkg::ST_MARK;
            end
            bth_pkg::ST_MARK: begin
                ram_we       = 1'b1;
                ram_waddr    = p_reg[AW-1:0];
                ram_wdata    = HDR_W'(size_reg) | HDR_W'(1);
                granted_next = 1'b1;
                payload_next = bth_pkg::PAY_W'((32'(p_reg) << 2) + 32'd4);
                state_next   = bth_pkg::ST_FB_RD;
            end
            bth_pkg::ST_W_ISSUE: begin
                if (n_reg == WC_W'(HEAP_WORDS) || pos_reg >= words_pos) begin
                    state_next = bth_pkg::ST_W_END;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = pos_reg[AW-1:0];
                    state_next = bth_pkg::ST_W_DATA;
                end
            end
            bth_pkg::ST_W_DATA: begin
                n_next = n_reg + WC_W'(1);
                if (ram_rdata == '0) begin
                    state_next = bth_pkg::ST_W_END;
                end else if (ram_rdata[0]) begin
                    // used chunk closes the current free run
                    if (run_reg != '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = best_reg[AW-1:0];
                        ram_wdata = run_reg;
                    end
                    if (run_reg != '0 && CMP_W'(run_reg) >= size_reg) begin
                        free_w_next = best_reg;
                        free_v_next = 1'b1;
                        fsize_next  = run_reg;
                        state_next  = bth_pkg::ST_SPLIT;
                    end else begin
                        run_next   = '0;
                        pos_next   = pos_adv;
                        best_next  = pos_adv;
                        state_next = (hdr_sz == '0) ? bth_pkg::ST_W_END : bth_pkg::ST_W_ISSUE;
                    end
                end else begin
                    run_next   = run_reg + hdr_sz;
                    pos_next   = pos_adv;
                    state_next = (hdr_sz == '0) ? bth_pkg::ST_W_END : bth_pkg::ST_W_ISSUE;
                end
            end
            bth_pkg::ST_W_END: begin
                if (run_reg != '0 && best_reg < words_pos) begin
                    ram_we    = 1'b1;
                    ram_waddr = best_reg[AW-1:0];
                    ram_wdata = run_reg;
                end
                if (run_reg != '0 && best_reg < words_pos && CMP_W'(run_reg) >= size_reg) begin
                    free_w_next = best_reg;
                    free_v_next = 1'b1;
                    fsize_next  = run_reg;
                    state_next  = bth_pkg::ST_SPLIT;
                end else begin
                    free_v_next = 1'b0;
                    state_next  = bth_pkg::ST_FB_RD;
                end
            end
            bth_pkg::ST_FB_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = free_w_reg[AW-1:0];
                state_next = bth_pkg::ST_FB_OUT;
            end
            bth_pkg::ST_FB_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, fb_val, payload_reg, granted_reg};
                    state_next   = bth_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bth_pkg::ST_INIT0;
            end
        endcase

        // heap rebuild
        if (cfg_we) begin
            words_next  = cfg_words;
            free_w_next = '0;
            free_v_next = 1'b1;
            state_next  = bth_pkg::ST_INIT0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bth_pkg::ST_INIT0;
            words_reg   <= WC_W'(RST_WORDS);
            free_w_reg  <= '0;
            free_v_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            words_reg   <= words_next;
            free_w_reg  <= free_w_next;
            free_v_reg  <= free_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg    <= size_next;
        fsize_reg   <= fsize_next;
        p_reg       <= p_next;
        pos_reg     <= pos_next;
        best_reg    <= best_next;
        run_reg     <= run_next;
        n_reg       <= n_next;
        rel_w_reg   <= rel_w_next;
        granted_reg <= granted_next;
        payload_reg <= payload_next;
        m_data_reg  <= m_data_next;
    end

endmodule

FILE: tb/boundary_tag_heap_allocator_tb.sv
module boundary_tag_heap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_WORDS  = 4096;
    localparam int STALL_LIMIT = 50000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic                      kind;
        logic [bth_pkg::REQ_W-1:0] req;
        logic [bth_pkg::REL_W-1:0] rel;
    } heap_op_t;

    typedef struct packed {
        logic                      granted;
        logic [bth_pkg::PAY_W-1:0] payload;
        logic [bth_pkg::FB_W-1:0]  free_bytes;
    } heap_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [14:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    boundary_tag_heap_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the heap
    logic [15:0]      hdr_model [HEAP_WORDS];
    int unsigned      heap_len;
    int unsigned      free_off;
    bit               free_ok;
    logic [bth_pkg::REL_W-1:0] live_payloads [$];

    heap_op_t     pending_ops [$];
    heap_result_t expected_results [$];
    heap_op_t     drv_op;
    int           drv_gap = 0;
    int           drv_gap_max = 8;
    int           rcv_gap = 0;
    int           rcv_gap_max = 8;
    int           results_seen = 0;
    int           mismatch_count = 0;
    int           stall_cycles = 0;

    function automatic void lay_out_heap(logic [14:0] bytes);
        int unsigned len;
        len = (32'(bytes) + 32'd3) & ~32'd3;
        if (len < 8) len = 8;
        if (len > HEAP_WORDS * 4) len = HEAP_WORDS * 4;
        heap_len = len;
        foreach (hdr_model[i]) hdr_model[i] = '0;
        hdr_model[0] = 16'(len - 4);
        hdr_model[(len >> 2) - 1] = '0;
        free_off = 0;
        free_ok = 1'b1;
        live_payloads.delete();
    endfunction

    // Walk from offset 0, coalescing free runs; first run big enough wins
    function automatic bit first_fit_merge(int unsigned need, output int unsigned found);
        int unsigned words, pos, best, run, h, sz, n;
        words = heap_len >> 2;
        pos = 0;
        best = 0;
        run = 0;
        found = 0;
        for (n = 0; n < HEAP_WORDS; n++) begin
            if (pos >= words) break;
            h = hdr_model[pos];
            if (h == 0) break;
            sz = h & ~32'd3;
            if (h[0]) begin
                if (run != 0) begin
                    hdr_model[best] = 16'(run);
                    if (run >= need) begin
                        found = best;
                        return 1'b1;
                    end
                end
                run = 0;
                pos += sz >> 2;
                best = pos;
            end else begin
                run += sz;
                pos += sz >> 2;
            end
            if (sz == 0) break;
        end
        if (run != 0 && best < words) begin
            hdr_model[best] = 16'(run);
            if (run >= need) begin
                found = best;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic heap_result_t heap_outcome(heap_op_t op);
        int unsigned words, w, size, fw, found, p, fsize, nw;
        bit ok;
        heap_result_t r;
        r = '0;
        words = heap_len >> 2;
        if (op.kind == bth_pkg::KIND_RELEASE) begin
            if (op.rel >= 4) begin
                w = (32'(op.rel) >> 2) - 1;
                if (w + 1 < words) hdr_model[w][0] = 1'b0;
            end
        end else if (op.req != 0) begin
            size = (32'(op.req) + 32'd7) & ~32'd3;
            ok = 1'b1;
            fw = free_off >> 2;
            if (!free_ok || fw >= words || size > hdr_model[fw]) begin
                if (first_fit_merge(size, found)) begin
                    free_off = found << 2;
                    free_ok = 1'b1;
                end else begin
                    free_ok = 1'b0;
                    ok = 1'b0;
                end
            end
            if (ok) begin
                p = free_off >> 2;
                fsize = hdr_model[p];
                if (fsize >= size + 4) begin
                    nw = p + (size >> 2);
                    free_off = nw << 2;
                    if (nw < words) hdr_model[nw] = 16'(fsize - size);
                end else begin
                    // remainder too small for a header: hand over the whole chunk
                    free_ok = 1'b0;
                    size = fsize;
                end
                hdr_model[p] = 16'(size | 1);
                r.granted = 1'b1;
                r.payload = bth_pkg::PAY_W'((p << 2) + 4);
                live_payloads.push_back(r.payload);
            end
        end
        if (free_ok && (free_off >> 2) < words)
            r.free_bytes = bth_pkg::FB_W'(hdr_model[free_off >> 2]);
        return r;
    endfunction

    function automatic heap_op_t make_op(logic kind, int unsigned req, int unsigned rel);
        heap_op_t op;
        op.kind = kind;
        op.req = bth_pkg::REQ_W'(req);
        op.rel = bth_pkg::REL_W'(rel);
        return op;
    endfunction

    function automatic heap_op_t random_heap_op();
        heap_op_t op;
        int unsigned pick, sel, idx, half;
        op.req = bth_pkg::REQ_W'($urandom);
        op.rel = bth_pkg::REL_W'($urandom);
        pick = $urandom_range(0, 99);
        half = (heap_len / 2 > 49) ? heap_len / 2 : 49;
        if (pick < 52) begin
            op.kind = bth_pkg::KIND_ALLOC;
            sel = $urandom_range(0, 99);
            if (sel < 80)      op.req = bth_pkg::REQ_W'($urandom_range(1, 48));
            else if (sel < 92) op.req = bth_pkg::REQ_W'($urandom_range(49, half));
            else if (sel < 96) op.req = bth_pkg::REQ_W'($urandom_range(1, heap_len));
            else if (sel < 98) op.req = bth_pkg::REQ_W'($urandom);
            else               op.req = '0;
        end else begin
            op.kind = bth_pkg::KIND_RELEASE;
            if (pick < 90 && live_payloads.size() != 0) begin
                idx = $urandom_range(0, live_payloads.size() - 1);
                op.rel = live_payloads[idx];
                live_payloads.delete(idx);
            end else if (pick < 95) begin
                // stray offsets, unaligned ones and ones past the terminator included
                op.rel = bth_pkg::REL_W'($urandom_range(0, heap_len + 8));
            end
        end
        return op;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(logic [31:0] got);
        heap_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding, tdata", got, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got[0] !== want.granted)
            report_mismatch("granted", got[0], want.granted);
        if (got[14:1] !== want.payload)
            report_mismatch("payload_offset", got[14:1], want.payload);
        if (got[29:15] !== want.free_bytes)
            report_mismatch("free_bytes", got[29:15], want.free_bytes);
    endtask

    // Sender: each transaction is followed by a random gap
    always @(posedge aclk) begin : driver
        heap_op_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(heap_outcome(drv_op));
            if (!s_tvalid || s_tready) begin
                if (drv_gap != 0) begin
                    drv_gap <= drv_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    nxt = pending_ops.pop_front();
                    drv_op <= nxt;
                    s_tdata <= {2'b00, nxt.rel, nxt.req};
                    s_tuser <= nxt.kind;
                    s_tvalid <= 1'b1;
                    drv_gap <= $urandom_range(0, drv_gap_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall after each transaction, a long hold now and then
    always @(posedge aclk) begin : monitor
        if (!aresetn) begin
            m_tready <= 1'b0;
            rcv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                results_seen++;
                rcv_gap = $urandom_range(0, rcv_gap_max);
                if (results_seen % 450 == 200) rcv_gap = LONG_HOLD;
            end else if (rcv_gap != 0) begin
                rcv_gap--;
            end
            m_tready <= (rcv_gap == 0);
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_heap_bytes(logic [14:0] bytes);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= bytes;
        @(posedge aclk);
        cfg_we <= 1'b0;
        lay_out_heap(bytes);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int ph, k, n_items;
        logic [14:0] bytes;
        lay_out_heap(15'(bth_pkg::RESET_BYTES));
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset heap
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 0, 0));  // zero request fails
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 1, 0));
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 16'hFFFF, 0)); // walk, nothing fits
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 8, 0));  // walk after free ptr lost
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 0));     // null release
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 1));     // header below heap
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 3));
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 6));     // unaligned
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 16383)); // not a live header
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 4, 0));
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 12));
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 16380, 0)); // coalescing walk
        wait_drained();

        write_heap_bytes(15'd16);
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 5, 0));   // exact fit, whole chunk
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 1, 0));
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 4));
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 2, 0));
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 12));
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 16)); // terminator word
        wait_drained();

        write_heap_bytes(15'd0);                                       // clamps to minimum
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 1, 0));
        pending_ops.push_back(make_op(bth_pkg::KIND_RELEASE, 0, 4));
        pending_ops.push_back(make_op(bth_pkg::KIND_ALLOC, 0, 0));

        for (ph = 0; ph < 12; ph++) begin
            wait_drained();
            case (ph)
                0:       bytes = 15'h7FFF;
                1:       bytes = 15'd100;
                2:       bytes = 15'd257;
                3:       bytes = 15'd0;
                4:       bytes = 15'd512;
                5:       bytes = 15'd1023;
                6:       bytes = 15'd2048;
                7:       bytes = 15'(bth_pkg::RESET_BYTES);
                default: bytes = 15'($urandom_range(8, 4096));
            endcase
            write_heap_bytes(bytes);
            drv_gap_max = (ph % 3 == 1) ? 0 : 8;
            rcv_gap_max = (ph % 4 == 2) ? 0 : 8;
            n_items = (heap_len <= 8) ? 20 : 100;
            // small batches so releases can target payloads granted so far
            while (n_items > 0) begin
                for (k = 0; k < 8 && n_items > 0; k++) begin
                    pending_ops.push_back(random_heap_op());
                    n_items--;
                end
                while (pending_ops.size() != 0) @(negedge aclk);
            end
        end

        wait_drained();
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bth_pkg.sv
rtl/bth_ram.sv
rtl/boundary_tag_heap_allocator.sv
tb/boundary_tag_heap_allocator_tb.sv
